### sv/rkw_pkg.sv
package rkw_pkg;

  // payload words
  typedef struct packed {
    logic [8:0] pos_x;
    logic [8:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [16:0] weight;
    logic        outside_stamp;
  } out_item_t;

  // register map
  localparam int          CFG_AW       = 4;
  localparam logic [1:0]  REG_RADIUS   = 2'd0;
  localparam logic [1:0]  REG_DEV      = 2'd1;
  localparam logic [1:0]  REG_MODE     = 2'd2;

  // kernel codes
  localparam logic [1:0]  KERNEL_LINEAR = 2'd0;
  localparam logic [1:0]  KERNEL_SQRT   = 2'd1;
  localparam logic [1:0]  KERNEL_EXP    = 2'd2;

  // reset values
  localparam logic [7:0]  RADIUS_RST = 8'd1;
  localparam logic [15:0] DEV_RST    = 16'd2560;
  localparam logic [1:0]  MODE_RST   = KERNEL_EXP;

  // fixed point constants
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] DIST_MAX    = 17'd131071;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] E1_Q30      = 31'd395007567;
  localparam logic [31:0] ROUND_Q14   = 32'd8192;
  localparam int          EXP_TERMS   = 10;
  localparam int          EXP_POW_STG = 15;

  // floor(2^32 / k) for the series divisors
  function automatic logic [32:0] exp_recip(input int k);
    logic [32:0] m;
    case (k)
      1:       m = 33'd4294967296;
      2:       m = 33'd2147483648;
      3:       m = 33'd1431655765;
      4:       m = 33'd1073741824;
      5:       m = 33'd858993459;
      6:       m = 33'd715827882;
      7:       m = 33'd613566756;
      8:       m = 33'd536870912;
      9:       m = 33'd477218588;
      10:      m = 33'd429496729;
      default: m = 33'd0;
    endcase
    return m;
  endfunction

endpackage

### sv/rkw_isqrt_pipe.sv
module rkw_isqrt_pipe #(
  parameter int IW = 50,
  parameter int SW = 1,
  localparam int OW = IW / 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [IW-1:0] in_val,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [OW-1:0] out_root,
  output logic [SW-1:0] out_side
);

  localparam int RW = OW + 2;

  logic          vld_r  [OW];
  logic [RW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];
  logic [IW-1:0] val_r  [OW];
  logic [SW-1:0] side_r [OW];

  // one root bit per stage, two radicand bits brought down each time
  for (genvar j = 0; j < OW; j++) begin : g_stage
    logic          vld_p;
    logic [RW-1:0] rem_p;
    logic [OW-1:0] root_p;
    logic [IW-1:0] val_p;
    logic [SW-1:0] side_p;
    logic [RW+1:0] cat;
    logic [RW+1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign val_p  = in_val;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[j-1];
      assign rem_p  = rem_r[j-1];
      assign root_p = root_r[j-1];
      assign val_p  = val_r[j-1];
      assign side_p = side_r[j-1];
    end

    assign cat   = {rem_p, val_p[IW-1-2*j -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = (cat >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_p;
      end
      rem_r[j]  <= ge ? RW'(cat - trial) : cat[RW-1:0];
      root_r[j] <= {root_p[OW-2:0], ge};
      val_r[j]  <= val_p;
      side_r[j] <= side_p;
    end
  end

  assign out_valid = vld_r[OW-1];
  assign out_root  = root_r[OW-1];
  assign out_side  = side_r[OW-1];

endmodule

### sv/rkw_div_pipe.sv
module rkw_div_pipe #(
  parameter int NW = 25,
  parameter int DW = 9,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic          vld_p;
    logic [DW-1:0] rem_p;
    logic [NW-1:0] quo_p;
    logic [NW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [SW-1:0] side_p;
    logic [DW:0]   cat;
    logic          ge;

    if (j == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rem_p  = '0;
      assign quo_p  = '0;
      assign num_p  = in_num;
      assign den_p  = in_den;
      assign side_p = in_side;
    end else begin : g_next
      assign vld_p  = vld_r[j-1];
      assign rem_p  = rem_r[j-1];
      assign quo_p  = quo_r[j-1];
      assign num_p  = num_r[j-1];
      assign den_p  = den_r[j-1];
      assign side_p = side_r[j-1];
    end

    assign cat = {rem_p, num_p[NW-1-j]};
    assign ge  = (cat >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_p;
      end
      rem_r[j]  <= ge ? DW'(cat - {1'b0, den_p}) : cat[DW-1:0];
      quo_r[j]  <= {quo_p[NW-2:0], ge};
      num_r[j]  <= num_p;
      den_r[j]  <= den_p;
      side_r[j] <= side_p;
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quo   = quo_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

### sv/rkw_exp_pipe.sv
module rkw_exp_pipe import rkw_pkg::*; #(
  parameter int SW = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [15:0]   in_frac,
  input  logic [3:0]    in_int,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [30:0]   out_acc,
  output logic [SW-1:0] out_side
);

  // context carried along: series argument, integer part, sideband
  localparam int CW = 30 + 4 + SW;

  logic [CW-1:0] ctx_in;
  assign ctx_in = {in_frac, 14'd0, in_int, in_side};

  // series stages: product, reciprocal multiply, correct and subtract
  logic          a_vld_r [EXP_TERMS];
  logic [30:0]   a_p_r   [EXP_TERMS];
  logic [CW-1:0] a_ctx_r [EXP_TERMS];
  logic          b_vld_r [EXP_TERMS];
  logic [30:0]   b_p_r   [EXP_TERMS];
  logic [30:0]   b_q_r   [EXP_TERMS];
  logic [CW-1:0] b_ctx_r [EXP_TERMS];
  logic          c_vld_r [EXP_TERMS];
  logic [30:0]   c_acc_r [EXP_TERMS];
  logic [CW-1:0] c_ctx_r [EXP_TERMS];

  for (genvar t = 0; t < EXP_TERMS; t++) begin : g_term
    localparam int          K     = EXP_TERMS - t;
    localparam logic [32:0] RECIP = exp_recip(K);
    logic          vld_p;
    logic [30:0]   acc_p;
    logic [CW-1:0] ctx_p;
    logic [60:0]   prod;
    logic [63:0]   pm;
    logic [34:0]   qk;
    logic [34:0]   rem;
    logic          corr;
    logic [30:0]   quo;

    if (t == 0) begin : g_first
      assign vld_p = in_valid;
      assign acc_p = ONE_Q30;
      assign ctx_p = ctx_in;
    end else begin : g_next
      assign vld_p = c_vld_r[t-1];
      assign acc_p = c_acc_r[t-1];
      assign ctx_p = c_ctx_r[t-1];
    end

    assign prod = 61'(acc_p) * 61'(ctx_p[CW-1 -: 30]);
    assign pm   = 64'(a_p_r[t]) * 64'(RECIP);
    assign qk   = 35'(b_q_r[t]) * 35'(K);
    assign rem  = 35'(b_p_r[t]) - qk;
    assign corr = (rem >= 35'(K));
    assign quo  = b_q_r[t] + 31'(corr);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r[t] <= 1'b0;
        b_vld_r[t] <= 1'b0;
        c_vld_r[t] <= 1'b0;
      end else begin
        a_vld_r[t] <= vld_p;
        b_vld_r[t] <= a_vld_r[t];
        c_vld_r[t] <= b_vld_r[t];
      end
      a_p_r[t]   <= prod[60:30];
      a_ctx_r[t] <= ctx_p;
      b_p_r[t]   <= a_p_r[t];
      b_q_r[t]   <= pm[62:32];
      b_ctx_r[t] <= a_ctx_r[t];
      c_acc_r[t] <= ONE_Q30 - quo;
      c_ctx_r[t] <= b_ctx_r[t];
    end
  end

  // integer part: multiply by exp(-1) once per unit
  logic          p_vld_r [EXP_POW_STG];
  logic [30:0]   p_acc_r [EXP_POW_STG];
  logic [CW-1:0] p_ctx_r [EXP_POW_STG];

  for (genvar i = 0; i < EXP_POW_STG; i++) begin : g_pow
    logic          vld_p;
    logic [30:0]   acc_p;
    logic [CW-1:0] ctx_p;
    logic [59:0]   prod;
    logic [3:0]    n_p;

    if (i == 0) begin : g_first
      assign vld_p = c_vld_r[EXP_TERMS-1];
      assign acc_p = c_acc_r[EXP_TERMS-1];
      assign ctx_p = c_ctx_r[EXP_TERMS-1];
    end else begin : g_next
      assign vld_p = p_vld_r[i-1];
      assign acc_p = p_acc_r[i-1];
      assign ctx_p = p_ctx_r[i-1];
    end

    assign n_p  = ctx_p[SW+3 -: 4];
    assign prod = 60'(acc_p) * 60'(E1_Q30);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_vld_r[i] <= 1'b0;
      end else begin
        p_vld_r[i] <= vld_p;
      end
      p_acc_r[i] <= (n_p > 4'(i)) ? prod[60-1:30] + 31'd0 : acc_p;
      p_ctx_r[i] <= ctx_p;
    end
  end

  assign out_valid = p_vld_r[EXP_POW_STG-1];
  assign out_acc   = p_acc_r[EXP_POW_STG-1];
  assign out_side  = p_ctx_r[EXP_POW_STG-1][SW-1:0];

endmodule

### sv/radial_kernel_stamp_weight_core.sv
// Radial heatmap stamp weight. One (pos_x, pos_y) word is taken per clock whenever start is
// high; busy is always low. Each word yields exactly one result word, shown on out_data for
// one cycle with out_valid high, in the order taken. The pipeline is made up mostly of the
// per-stage chains: the distance square root (25 stages), the divide by r+1 and the
// divide by the deviation (25 stages each), the kernel square root (21 stages) and the exp
// series with its integer power (45 stages). Results cannot be held off, so the receiver
// must take every word. Write the registers only when no word is in flight.
module radial_kernel_stamp_weight_core import rkw_pkg::*; #(
  parameter int MAX_RADIUS = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [9:0] MAX_R = 10'(MAX_RADIUS);

  // configuration registers
  logic [7:0]  radius_r;
  logic [15:0] dev_r;
  logic [1:0]  mode_r;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      dev_r    <= DEV_RST;
      mode_r   <= MODE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RADIUS: radius_r <= pwdata[7:0];
        REG_DEV:    dev_r    <= pwdata[15:0];
        REG_MODE:   mode_r   <= pwdata[1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS: prdata = {24'd0, radius_r};
      REG_DEV:    prdata = {16'd0, dev_r};
      REG_MODE:   prdata = {30'd0, mode_r};
      default:    prdata = 32'd0;
    endcase
  end

  // effective radius and divisors
  logic [7:0]  r_eff;
  logic [8:0]  two_r;
  logic [8:0]  r_plus1;
  logic [15:0] dev_eff;

  assign r_eff   = ({2'b00, radius_r} > MAX_R) ? MAX_R[7:0] : radius_r;
  assign two_r   = {r_eff, 1'b0};
  assign r_plus1 = {1'b0, r_eff} + 9'd1;
  assign dev_eff = (dev_r == 16'd0) ? 16'd1 : dev_r;

  // input register
  logic       s1_vld_r;
  logic [8:0] s1_x_r;
  logic [8:0] s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_x_r <= in_data.pos_x;
    s1_y_r <= in_data.pos_y;
  end

  // offsets from center, out-of-stamp flag
  logic       s2_vld_r;
  logic       s2_out_r;
  logic [7:0] s2_dx_r;
  logic [7:0] s2_dy_r;
  logic       out_nxt;
  logic [8:0] dx_full;
  logic [8:0] dy_full;

  assign out_nxt = (s1_x_r > two_r) || (s1_y_r > two_r);
  assign dx_full = (s1_x_r >= {1'b0, r_eff}) ? s1_x_r - {1'b0, r_eff}
                                              : {1'b0, r_eff} - s1_x_r;
  assign dy_full = (s1_y_r >= {1'b0, r_eff}) ? s1_y_r - {1'b0, r_eff}
                                              : {1'b0, r_eff} - s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_out_r <= out_nxt;
    s2_dx_r  <= out_nxt ? 8'd0 : dx_full[7:0];
    s2_dy_r  <= out_nxt ? 8'd0 : dy_full[7:0];
  end

  // squares
  logic        s3_vld_r;
  logic        s3_out_r;
  logic [15:0] s3_dx2_r;
  logic [15:0] s3_dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_out_r <= s2_out_r;
    s3_dx2_r <= 16'(s2_dx_r) * 16'(s2_dx_r);
    s3_dy2_r <= 16'(s2_dy_r) * 16'(s2_dy_r);
  end

  // squared distance
  logic        s4_vld_r;
  logic        s4_out_r;
  logic [16:0] s4_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_out_r <= s3_out_r;
    s4_s_r   <= {1'b0, s3_dx2_r} + {1'b0, s3_dy2_r};
  end

  // distance in Q.16
  logic        sq1_vld;
  logic [24:0] sq1_root;
  logic        sq1_out;

  rkw_isqrt_pipe #(.IW(50), .SW(1)) u_sqrt_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_vld_r),
    .in_val    ({1'b0, s4_s_r, 32'd0}),
    .in_side   (s4_out_r),
    .out_valid (sq1_vld),
    .out_root  (sq1_root),
    .out_side  (sq1_out)
  );

  // normalize by r+1
  logic        dv1_vld;
  logic [24:0] dv1_quo;
  logic        dv1_out;
  logic [16:0] dist_q16;

  rkw_div_pipe #(.NW(25), .DW(9), .SW(1)) u_div_radius (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq1_vld),
    .in_num    (sq1_root),
    .in_den    (r_plus1),
    .in_side   (sq1_out),
    .out_valid (dv1_vld),
    .out_quo   (dv1_quo),
    .out_side  (dv1_out)
  );

  assign dist_q16 = (dv1_quo > {8'd0, DIST_MAX}) ? DIST_MAX : dv1_quo[16:0];

  // scale by deviation for the exp kernel
  logic        dv2_vld;
  logic [24:0] dv2_quo;
  logic [17:0] dv2_side;

  rkw_div_pipe #(.NW(25), .DW(16), .SW(18)) u_div_dev (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv1_vld),
    .in_num    ({dist_q16, 8'd0}),
    .in_den    (dev_eff),
    .in_side   ({dv1_out, dist_q16}),
    .out_valid (dv2_vld),
    .out_quo   (dv2_quo),
    .out_side  (dv2_side)
  );

  // shared root for the sqrt and exp kernels
  logic        sqrt_mode;
  logic        lin_mode;
  logic [41:0] sq2_in;
  logic        sq2_vld;
  logic [20:0] sq2_root;
  logic [17:0] sq2_side;

  assign lin_mode  = (mode_r == KERNEL_LINEAR);
  assign sqrt_mode = (mode_r == KERNEL_SQRT);
  assign sq2_in    = sqrt_mode ? {9'd0, dv2_side[16:0], 16'd0} : {1'b0, dv2_quo, 16'd0};

  rkw_isqrt_pipe #(.IW(42), .SW(18)) u_sqrt_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv2_vld),
    .in_val    (sq2_in),
    .in_side   (dv2_side),
    .out_valid (sq2_vld),
    .out_root  (sq2_root),
    .out_side  (sq2_side)
  );

  // exp kernel; linear and sqrt values ride along
  logic [16:0] alt_shaped;
  logic        ex_vld;
  logic [30:0] ex_acc;
  logic [18:0] ex_side;

  assign alt_shaped = lin_mode ? sq2_side[16:0] : sq2_root[16:0];

  rkw_exp_pipe #(.SW(19)) u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq2_vld),
    .in_frac   (sq2_root[16:1]),
    .in_int    (sq2_root[20:17]),
    .in_side   ({sq2_side[17], ~(lin_mode | sqrt_mode), alt_shaped}),
    .out_valid (ex_vld),
    .out_acc   (ex_acc),
    .out_side  (ex_side)
  );

  // round, clamp and form the weight
  logic [31:0] exp_round;
  logic [17:0] shaped;
  logic [16:0] shaped_c;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   out_data_nxt;

  assign exp_round = {1'b0, ex_acc} + ROUND_Q14;
  assign shaped    = ex_side[17] ? exp_round[31:14] : {1'b0, ex_side[16:0]};
  assign shaped_c  = (shaped > {1'b0, ONE_Q16}) ? ONE_Q16 : shaped[16:0];

  always_comb begin
    out_data_nxt.outside_stamp = ex_side[18];
    out_data_nxt.weight        = ex_side[18] ? 17'd0 : ONE_Q16 - shaped_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ex_vld;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sim/tb_top.sv
module tb_top;
  import rkw_pkg::*;

  localparam int LATENCY   = 146;
  localparam int CYCLE_CAP = 400000;
  localparam int N_RANDOM  = 650;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_data;
  logic              out_valid;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  radial_kernel_stamp_weight_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the register file
  logic [7:0]  radius_sh;
  logic [15:0] dev_sh;
  logic [1:0]  mode_sh;

  out_item_t weight_q[$];
  int        mismatches;
  int        words_sent;
  int        words_checked;
  int        cycles;

  // directed stimulus table
  typedef struct {
    logic [7:0]  rad;
    logic [15:0] dev;
    logic [1:0]  mode;
    logic [8:0]  x;
    logic [8:0]  y;
    bit          typed;
    logic [16:0] w;
    logic        outside;
  } stamp_row_t;

  stamp_row_t rows[16];

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // floor square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // exp(-fx) in q2.30 by horner series
  function automatic longint unsigned exp_series_q30(input longint unsigned fx);
    longint unsigned acc;
    acc = 64'd1 << 30;
    for (int k = 10; k >= 1; k--)
      acc = (64'd1 << 30) - (((acc * fx) >> 30) / k);
    return acc;
  endfunction

  // expected stamp weight for one position under the shadow registers
  function automatic out_item_t stamp_weight(input logic [8:0] x, input logic [8:0] y);
    out_item_t       o;
    longint unsigned r, dx, dy, s, dist_q, shaped, dv, q, t, u, n, acc, e1;
    r = radius_sh;
    o.weight = '0;
    o.outside_stamp = 1'b1;
    if (x > 2 * r || y > 2 * r) return o;
    dx = (x >= r) ? x - r : r - x;
    dy = (y >= r) ? y - r : r - y;
    s = dx * dx + dy * dy;
    dist_q = int_sqrt(s << 32) / (r + 1);
    if (dist_q > 131071) dist_q = 131071;
    if (mode_sh == KERNEL_LINEAR) begin
      shaped = dist_q;
    end else if (mode_sh == KERNEL_SQRT) begin
      shaped = int_sqrt(dist_q << 16);
    end else begin
      dv = (dev_sh == 0) ? 1 : dev_sh;
      q = (dist_q << 8) / dv;
      t = int_sqrt(q << 16);
      u = t >> 1;
      n = u >> 16;
      if (n > 16) begin
        shaped = 0;
      end else begin
        acc = exp_series_q30((u & 64'hFFFF) << 14);
        e1 = exp_series_q30(64'd1 << 30);
        for (longint unsigned i = 0; i < n; i++) acc = (acc * e1) >> 30;
        shaped = (acc + (64'd1 << 13)) >> 14;
      end
    end
    if (shaped > 65536) shaped = 65536;
    o.weight = 17'(65536 - shaped);
    o.outside_stamp = 1'b0;
    return o;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (weight_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: weight %0d outside %0b", out_data.weight,
                   out_data.outside_stamp);
      end else begin
        want = weight_q.pop_front();
        words_checked++;
        if (out_data.weight !== want.weight || out_data.outside_stamp !== want.outside_stamp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: weight exp %0d got %0d, outside exp %0b got %0b",
                     want.weight, out_data.weight, want.outside_stamp,
                     out_data.outside_stamp);
        end
      end
    end
  end

  // apb write, setup then access phase
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx) << 2;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // drain the pipe, then load all three registers
  task automatic load_config(input logic [7:0] rad, input logic [15:0] dev,
                             input logic [1:0] mode);
    start <= 1'b0;
    @(negedge clk);
    while (weight_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    reg_write(REG_RADIUS, 32'(rad));
    reg_write(REG_DEV, 32'(dev));
    reg_write(REG_MODE, 32'(mode));
    radius_sh = rad;
    dev_sh    = dev;
    mode_sh   = mode;
  endtask

  // present one word; start stays high on return
  task automatic send_word(input logic [8:0] x, input logic [8:0] y, input bit typed,
                           input out_item_t typed_res);
    out_item_t want;
    start   <= 1'b1;
    in_data <= {x, y};
    @(posedge clk);
    while (busy) @(posedge clk);
    want = stamp_weight(x, y);
    if (typed && want !== typed_res)
      $display("note: table row (%0d,%0d) differs from prediction", x, y);
    weight_q.push_back(typed ? typed_res : want);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int len);
    start <= 1'b0;
    repeat (len) @(negedge clk);
  endtask

  initial begin
    out_item_t  tr;
    logic [7:0] rr;
    logic [15:0] dd;
    logic [1:0] mm;
    logic [8:0] px, py;
    rst_n = 1'b0;  start = 1'b0;  in_data = '0;
    psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
    mismatches = 0;  words_sent = 0;  words_checked = 0;  cycles = 0;
    radius_sh = RADIUS_RST;  dev_sh = DEV_RST;  mode_sh = MODE_RST;

    // reset defaults first, then extremes of radius, deviation and mode
    rows[0]  = '{8'd1, 16'd2560, KERNEL_EXP, 9'd1, 9'd1, 1, 17'd0, 1'b0};
    rows[1]  = '{8'd1, 16'd2560, KERNEL_EXP, 9'd0, 9'd0, 0, 17'd0, 1'b0};
    rows[2]  = '{8'd1, 16'd2560, KERNEL_EXP, 9'd2, 9'd2, 0, 17'd0, 1'b0};
    rows[3]  = '{8'd1, 16'd2560, KERNEL_EXP, 9'd3, 9'd0, 1, 17'd0, 1'b1};
    rows[4]  = '{8'd1, 16'd2560, KERNEL_EXP, 9'd510, 9'd510, 1, 17'd0, 1'b1};
    rows[5]  = '{8'd0, 16'd2560, KERNEL_LINEAR, 9'd0, 9'd0, 1, 17'd65536, 1'b0};
    rows[6]  = '{8'd0, 16'd2560, KERNEL_LINEAR, 9'd1, 9'd0, 1, 17'd0, 1'b1};
    rows[7]  = '{8'd255, 16'd2560, KERNEL_LINEAR, 9'd510, 9'd510, 1, 17'd0, 1'b0};
    rows[8]  = '{8'd255, 16'd2560, KERNEL_LINEAR, 9'd255, 9'd255, 1, 17'd65536, 1'b0};
    rows[9]  = '{8'd255, 16'd2560, KERNEL_SQRT, 9'd0, 9'd255, 0, 17'd0, 1'b0};
    rows[10] = '{8'd255, 16'd2560, KERNEL_SQRT, 9'd255, 9'd255, 1, 17'd65536, 1'b0};
    // zero deviation acts as one lsb
    rows[11] = '{8'd255, 16'd0, KERNEL_EXP, 9'd0, 9'd0, 0, 17'd0, 1'b0};
    // tiny deviation gives the largest exponent
    rows[12] = '{8'd255, 16'd1, KERNEL_EXP, 9'd0, 9'd0, 0, 17'd0, 1'b0};
    rows[13] = '{8'd255, 16'd65535, KERNEL_EXP, 9'd10, 9'd300, 0, 17'd0, 1'b0};
    // unused kernel code behaves as exponential
    rows[14] = '{8'd200, 16'd3, 2'd3, 9'd0, 9'd400, 0, 17'd0, 1'b0};
    rows[15] = '{8'd37, 16'd777, KERNEL_SQRT, 9'd5, 9'd60, 0, 17'd0, 1'b0};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    foreach (rows[i]) begin
      if (rows[i].rad !== radius_sh || rows[i].dev !== dev_sh || rows[i].mode !== mode_sh)
        load_config(rows[i].rad, rows[i].dev, rows[i].mode);
      tr.weight = rows[i].w;
      tr.outside_stamp = rows[i].outside;
      send_word(rows[i].x, rows[i].y, rows[i].typed, tr);
      if ($urandom_range(0, 99) < 33) idle_gap($urandom_range(1, 3));
    end

    // random phases, each under a fresh register setting
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 65 == 0) begin
        case ($urandom_range(0, 3))
          0:       rr = 8'd255;
          1:       rr = 8'($urandom_range(0, 255));
          default: rr = 8'($urandom_range(0, 20));
        endcase
        if (i == 0 || i == 325) rr = 8'd255;
        case ($urandom_range(0, 4))
          0:       dd = 16'd0;
          1:       dd = 16'hFFFF;
          2:       dd = 16'($urandom_range(1, 255));
          default: dd = 16'($urandom);
        endcase
        mm = 2'($urandom_range(0, 3));
        load_config(rr, dd, mm);
      end
      // hold off until the pipe is empty once
      if (i == 400) begin
        idle_gap(1);
        while (weight_q.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 99) < 85) begin
        px = 9'($urandom_range(0, 2 * radius_sh));
        py = 9'($urandom_range(0, 2 * radius_sh));
      end else begin
        px = 9'($urandom_range(0, 510));
        py = 9'($urandom_range(0, 510));
      end
      send_word(px, py, 0, '0);
      // steady burst with no gaps in the middle of the run
      if ((i < 200 || i > 350) && $urandom_range(0, 99) < 33)
        idle_gap($urandom_range(1, 2));
    end

    // drain and watch for stray words
    start <= 1'b0;
    @(negedge clk);
    while (weight_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);

    $display("sent %0d words, checked %0d, %0d mismatches", words_sent, words_checked,
             mismatches);
    $display("covered reset values, radius 0 and 255, all kernels, zero and full deviation");
    if (mismatches == 0 && weight_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
